// File: rtl/erts_pkg.sv
package erts_pkg;

  typedef enum logic [2:0] {
    OUT_PAUSED   = 3'd0,
    OUT_NOT_DUE  = 3'd1,
    OUT_UPDATED  = 3'd2,
    OUT_BOOT     = 3'd3,
    OUT_SPEND    = 3'd4,
    OUT_GAIN     = 3'd5,
    OUT_FROZEN   = 3'd6
  } outcome_e;

  localparam logic [1:0] REG_SMOOTH   = 2'd0;
  localparam logic [1:0] REG_RATIO    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_GAINS    = 2'd3;

  localparam logic [16:0] ALPHA_LOW  = 17'd6554;
  localparam logic [16:0] ALPHA_MED  = 17'd13107;
  localparam logic [16:0] ALPHA_HIGH = 17'd26214;
  localparam logic [11:0] RATIO_DEF  = 12'd768;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] time_ms;
    logic [3:0]  slot;
    logic [31:0] value;
    logic        paused;
    logic        work;
  } job_t;

  typedef struct packed {
    logic [1:0]  smooth;
    logic [11:0] ratio;
    logic        gains;
  } cfg_t;

endpackage

// File: rtl/erts_front.sv
module erts_front #(
  parameter int unsigned DefaultIntervalMs = 250
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        time_ms_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               frame_end_i,
  input  logic [15:0]        interval_i,
  input  logic               slot_ok_i,
  output logic               q_push_o,
  input  logic               q_full_i,
  output erts_pkg::job_t     q_job_o
);
  import erts_pkg::*;

  logic [31:0] last_q, last_d;
  logic        have_q, have_d;
  logic [31:0] ivl;
  logic        paused, due, acc;

  assign full = q_full_i;
  assign acc  = push && !q_full_i;
  assign ivl  = (interval_i >= 16'd100 && interval_i <= 16'd1000) ?
                {16'd0, interval_i} : 32'(DefaultIntervalMs);
  assign paused = have_q && time_ms_i == last_q;
  assign due    = !have_q || (time_ms_i - last_q) >= ivl;

  always_comb begin
    last_d = last_q;
    have_d = have_q;
    if (acc && !paused && due && frame_end_i) begin
      last_d = time_ms_i;
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      have_q <= 1'b0;
    end else begin
      last_q <= last_d;
      have_q <= have_d;
    end
  end

  assign q_push_o        = acc;
  assign q_job_o.time_ms = time_ms_i;
  assign q_job_o.slot    = slot_i;
  assign q_job_o.value   = sample_value_i;
  assign q_job_o.paused  = paused;
  assign q_job_o.work    = !paused && due && slot_ok_i;
endmodule

// File: rtl/erts_fifo.sv
module erts_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  // two entry queue between front and back
  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= !wp_q;
      if (rd_i && !empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr_i && !full_o) - 2'(rd_i && !empty_o);
    end
  end
endmodule

// File: rtl/erts_div.sv
module erts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [41:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [41:0] quo_o
);
  // restoring divide, one quotient bit a cycle
  logic [41:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] sh;
  logic [33:0] diff;

  assign sh   = {rem_q[31:0], quo_q[41]};
  assign diff = {1'b0, sh} - {2'b0, den_q};
  assign done_o = busy_q && cnt_q == 6'd0;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd42;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      if (!diff[33]) begin
        rem_q <= diff[32:0];
        quo_q <= {quo_q[40:0], 1'b1};
      end else begin
        rem_q <= sh;
        quo_q <= {quo_q[40:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/erts_back.sv
module erts_back #(
  parameter int unsigned Slots = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  erts_pkg::job_t     q_job_i,
  output logic               q_pop_o,
  input  erts_pkg::cfg_t     cfg_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_slot_o,
  output logic signed [31:0] rate_ema_o,
  output logic [2:0]         outcome_o,
  output logic               slot_frozen_o,
  output logic               rate_valid_o
);
  import erts_pkg::*;

  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CMP, ST_MUL, ST_OUT
  } state_e;

  state_e state_q;

  logic [31:0]        btime_q [Slots];
  logic signed [31:0] bval_q  [Slots];
  logic signed [31:0] ema_q   [Slots];
  logic [Slots-1:0]   hasb_q, rdy_q, frz_q;

  job_t               job_q;
  logic [SlotW-1:0]   si;
  logic signed [32:0] dv_q;
  logic               neg_q;
  logic signed [31:0] inst_q;
  logic signed [33:0] diff_q;
  logic signed [51:0] prod_q;
  logic [2:0]         oc_q;
  logic               div_idle_q;

  logic               ov_q;
  logic [3:0]         oslot_q;
  logic signed [31:0] orate_q;
  logic [2:0]         ooc_q;
  logic               ofrz_q, ordy_q;

  logic               div_start, div_done;
  logic [41:0]        div_num, quo;
  logic [31:0]        dt;
  logic signed [32:0] dv;
  logic [42:0]        mag;
  logic signed [43:0] sq;
  logic signed [31:0] inst_sat;
  logic signed [31:0] ema;
  logic signed [44:0] lhs_sp, lhs_gn, rhs_sp, rhs_gn;
  logic [11:0]        ratio;
  logic [16:0]        alpha;
  logic signed [51:0] rnd;
  logic signed [35:0] sum;
  logic signed [31:0] ema_new;
  logic               alive, hb, frz_new;
  logic               in_range;

  assign si    = SlotW'(job_q.slot);
  assign ema   = ema_q[si];
  assign alive = rdy_q[si];
  assign hb    = hasb_q[si];
  assign dt    = job_q.time_ms - btime_q[si];
  assign dv    = 33'(signed'(job_q.value)) - 33'(bval_q[si]);
  assign mag   = 43'(dv[32] ? -dv : dv) * 43'd1000;
  assign div_num = mag[41:0];
  assign div_start = state_q == ST_DIV && !q_pop_o && dt != '0 && hb && div_idle_q;

  erts_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(dt),
    .done_o(div_done), .quo_o(quo)
  );

  // signed quotient, then saturate
  assign sq = neg_q ? -44'(quo) : 44'(quo);
  assign inst_sat = (sq > 44'sd2147483647) ? 32'sh7fffffff :
                    (sq < -44'sd2147483648) ? 32'sh80000000 : 32'(sq);

  assign ratio = (cfg_i.ratio == '0) ? RATIO_DEF : cfg_i.ratio;
  assign lhs_sp = -(45'(inst_q)) <<< 8;
  assign lhs_gn = 45'(inst_q) <<< 8;
  assign rhs_sp = 45'(ema) * $signed({1'b0, ratio});
  assign rhs_gn = (ema > 0) ? rhs_sp : '0;
  assign frz_new = hb && dv_q == '0;

  always_comb begin
    unique case (cfg_i.smooth)
      2'd0:    alpha = ALPHA_LOW;
      2'd2:    alpha = ALPHA_HIGH;
      default: alpha = ALPHA_MED;
    endcase
  end

  assign rnd = prod_q[51] ? -((-prod_q + 52'sd32768) >>> 16)
                          : ((prod_q + 52'sd32768) >>> 16);
  assign sum = 36'(ema) + 36'(rnd);
  assign ema_new = (sum > 36'sd2147483647) ? 32'sh7fffffff :
                   (sum < -36'sd2147483648) ? 32'sh80000000 : 32'(sum);

  // the next beat may start while the result register still waits
  assign q_pop_o = state_q == ST_IDLE && !q_empty_i;
  assign empty   = !ov_q;
  assign out_slot_o    = oslot_q;
  assign rate_ema_o    = orate_q;
  assign outcome_o     = ooc_q;
  assign slot_frozen_o = ofrz_q;
  assign rate_valid_o  = ordy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      div_idle_q <= 1'b1;
      hasb_q <= '0;
      rdy_q  <= '0;
      frz_q  <= '0;
      ov_q   <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        btime_q[i] <= '0;
        bval_q[i]  <= '0;
        ema_q[i]   <= '0;
      end
    end else begin
      if (pop && ov_q) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (q_pop_o) begin
          job_q <= q_job_i;
          state_q <= q_job_i.work ? ST_DIV : ST_OUT;
          oc_q <= q_job_i.paused ? OUT_PAUSED : OUT_NOT_DUE;
          div_idle_q <= 1'b1;
        end
        ST_DIV: begin
          dv_q  <= hb ? dv : '0;
          neg_q <= dv[32];
          if (!hb || dt == '0) begin
            inst_q <= '0;
            state_q <= ST_CMP;
          end else if (div_start) begin
            div_idle_q <= 1'b0;
          end else if (div_done) begin
            inst_q <= inst_sat;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          diff_q <= 34'(inst_q) - 34'(ema);
          frz_q[si] <= frz_new;
          priority if (alive && inst_q < 0 && lhs_sp > rhs_sp) oc_q <= OUT_SPEND;
          else if (alive && !cfg_i.gains && inst_q > 0 && lhs_gn > rhs_gn)
            oc_q <= OUT_GAIN;
          else if (frz_new) oc_q <= OUT_FROZEN;
          else if (alive) oc_q <= OUT_UPDATED;
          else oc_q <= OUT_BOOT;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q <= 52'(diff_q) * $signed({1'b0, alpha});
          state_q <= ST_OUT;
        end
        ST_OUT: if (!ov_q) begin
          if (job_q.work) begin
            if (oc_q == OUT_UPDATED) ema_q[si] <= ema_new;
            if (oc_q == OUT_BOOT) begin
              ema_q[si] <= inst_q;
              if (hb) rdy_q[si] <= 1'b1;
            end
            btime_q[si] <= job_q.time_ms;
            bval_q[si]  <= job_q.value;
            hasb_q[si]  <= 1'b1;
          end
          state_q <= ST_IDLE;
          ov_q <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result register follows final state of the slot
  assign in_range = 32'(job_q.slot) < 32'(Slots);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && !ov_q) begin
      oslot_q <= job_q.slot;
      ooc_q   <= (!in_range && oc_q == OUT_PAUSED) ? OUT_NOT_DUE : oc_q;
      if (!in_range) begin
        orate_q <= '0;
        ofrz_q  <= 1'b0;
        ordy_q  <= 1'b0;
      end else begin
        orate_q <= (job_q.work && oc_q == OUT_UPDATED) ? ema_new :
                   (job_q.work && oc_q == OUT_BOOT) ? inst_q : ema;
        ofrz_q  <= frz_q[si];
        ordy_q  <= alive || (job_q.work && oc_q == OUT_BOOT && hb);
      end
    end
  end
endmodule

// File: rtl/ema_rate_tracker_spike_reject_unit.sv
// ema rate tracker with spike rejection
// input queue side: push/full with time_ms_i, slot_i, sample_value_i,
// frame_end_i; a beat is taken when push is high and full is low
// result side: empty/pop; the oldest result sits on the out ports while
// empty is low and leaves on pop
// config channel: cfg_valid/cfg_ready with cfg_index/cfg_data, write only
// while idle; cfg_ready is always high
// a front stage stamps paused/due and frame timing, a two entry queue
// feeds the back unit which holds per slot state
// path to the result: paused or not-due beats go from the queue straight
// to the out state; due beats with no baseline or zero elapsed time pass
// the div, compare and multiply states; other due beats also wait in the
// div state for the 42 step serial divider for dv*1000/dt
// the back unit takes one item at a time, the next after the last leaves
// the out state; reset clears all slot state and config to defaults
// a stalled result register lets the back unit finish the next beat and
// then hold it; the queue then fills and full rises
module ema_rate_tracker_spike_reject_unit #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned DEFAULT_INTERVAL_MS = 250
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        time_ms_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               frame_end_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_slot_o,
  output logic signed [31:0] rate_ema_o,
  output logic [2:0]         outcome_o,
  output logic               slot_frozen_o,
  output logic               rate_valid_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import erts_pkg::*;

  cfg_t        cfg_q;
  logic [15:0] ivl_q;
  logic        qw, qf, qr, qe;
  job_t        jw, jr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smooth <= 2'd1;
      cfg_q.ratio  <= '0;
      cfg_q.gains  <= 1'b1;
      ivl_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SMOOTH:   cfg_q.smooth <= cfg_data[1:0];
        REG_RATIO:    cfg_q.ratio  <= cfg_data[11:0];
        REG_INTERVAL: ivl_q        <= cfg_data;
        REG_GAINS:    cfg_q.gains  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  erts_front #(.DefaultIntervalMs(DEFAULT_INTERVAL_MS)) u_front (
    .clk_i, .rst_ni, .push, .full, .time_ms_i, .slot_i, .sample_value_i,
    .frame_end_i, .interval_i(ivl_q), .slot_ok_i(32'(slot_i) < 32'(SLOTS)),
    .q_push_o(qw), .q_full_i(qf), .q_job_o(jw)
  );

  erts_fifo #(.Width($bits(job_t))) u_fifo (
    .clk_i, .rst_ni, .wr_i(qw), .wdata_i(jw), .full_o(qf),
    .rd_i(qr), .rdata_o(jr), .empty_o(qe)
  );

  erts_back #(.Slots(SLOTS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(qe), .q_job_i(jr), .q_pop_o(qr), .cfg_i(cfg_q),
    .empty, .pop, .out_slot_o, .rate_ema_o, .outcome_o, .slot_frozen_o,
    .rate_valid_o
  );
endmodule

// File: rtl/erts_checker.sv
module erts_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  outcome_o,
  input logic        rate_valid_o,
  input logic        slot_frozen_o,
  input logic [31:0] rate_ema_o
);
  import erts_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rate_ema_o))
    else $error("result changed while stalled");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outcome_o <= OUT_FROZEN)
    else $error("bad outcome");
  a_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && outcome_o == OUT_UPDATED |-> rate_valid_o)
    else $error("update without valid ema");
  a_frz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && outcome_o == OUT_FROZEN |-> slot_frozen_o)
    else $error("frozen skip without flag");
endmodule

bind ema_rate_tracker_spike_reject_unit erts_props u_chk (
  .clk_i, .rst_ni, .empty, .pop, .outcome_o, .rate_valid_o,
  .slot_frozen_o, .rate_ema_o
);
